[hw/rtl/bnc_pkg.sv]
package bnc_pkg;

  // Line buffer depth used when the top level is not overridden
  localparam int MAX_COLS_DEFAULT = 128;

  // Field widths
  localparam int ROWS_W  = 11;
  localparam int COLS_W  = 8;
  localparam int COUNT_W = 4;
  localparam int CFG_W   = ROWS_W;

  // Row counter holds up to frame_rows + 1
  localparam int ROW_POS_W = ROWS_W + 1;

  // Configuration register indexes
  localparam logic REG_FRAME_ROWS = 1'b0;
  localparam logic REG_FRAME_COLS = 1'b1;

  typedef struct packed {
    logic pixel;
    logic flush;
  } pixel_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               end_of_row;
    logic               end_of_frame;
  } count_item_t;

  // Number of set bits in a 3x3 window
  function automatic logic [COUNT_W-1:0] ones9(input logic [8:0] v);
    logic [COUNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < 9; i++) begin
      n = n + COUNT_W'(v[i]);
    end
    return n;
  endfunction

endpackage

[hw/rtl/bnc_stream_if.sv]
interface bnc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/bnc_ram.sv]
module bnc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port; read port returns old data on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[hw/rtl/binary_neighbor_count_3x3_unit.sv]
// 3x3 set-pixel count over a binary image streamed in raster order. The unit
// takes one pixel per clock and gives one count per clock while the output
// side keeps up; each result trails its pixel by one row and one column, so
// after the frame the host sends frame_cols+1 flush items to drain the last
// row, and the first frame_cols+1 items of a frame give no result. The two
// previous rows sit in one line-buffer RAM (one 2-bit entry per column): a
// pixel reads its column in the cycle it is taken and writes it back from the
// stage 1 registers, with the last write forwarded when the next pixel hits
// the same column. A result passes the stage 1 registers, then the output
// register. Per-column valid flags are cleared at reset, so no clearing pass
// is needed. Write frame_rows and frame_cols only while idle.
module binary_neighbor_count_3x3_unit #(
  parameter int MAX_COLS = bnc_pkg::MAX_COLS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  bnc_stream_if.sink               pixels,
  bnc_stream_if.source             counts,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [bnc_pkg::CFG_W-1:0] cfg_data
);
  import bnc_pkg::*;

  localparam int CA_W = $clog2(MAX_COLS);
  localparam int CN_W = ($clog2(MAX_COLS + 1) > COLS_W) ? $clog2(MAX_COLS + 1) : COLS_W;
  localparam logic [CN_W-1:0] MAX_COLS_N = CN_W'(MAX_COLS);

  // Configuration registers
  logic [ROWS_W-1:0] frame_rows;
  logic [COLS_W-1:0] frame_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rows <= ROWS_W'(1);
      frame_cols <= COLS_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_ROWS: frame_rows <= cfg_data[ROWS_W-1:0];
        REG_FRAME_COLS: frame_cols <= cfg_data[COLS_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size
  logic [ROW_POS_W-1:0] rows;
  logic [CN_W-1:0]      cols;
  logic [CN_W-1:0]      cols_raw;

  always_comb begin
    rows     = (frame_rows == '0) ? ROW_POS_W'(1) : ROW_POS_W'(frame_rows);
    cols_raw = (frame_cols == '0) ? CN_W'(1) : CN_W'(frame_cols);
    cols     = (cols_raw > MAX_COLS_N) ? MAX_COLS_N : cols_raw;
  end

  // Stage 0: position, row gating and line-buffer read
  logic [ROW_POS_W-1:0] row_position;
  logic [CA_W-1:0]      col_position;
  logic [CA_W-1:0]      c0;
  logic                 accept;
  logic                 top_en0, mid_en0, bot0, emit0, eof0;
  logic [CN_W-1:0]      c0_next;

  always_comb begin
    if (CN_W'(col_position) >= cols) begin
      c0 = CA_W'(cols - CN_W'(1));
    end else begin
      c0 = col_position;
    end
    c0_next = CN_W'(c0) + CN_W'(1);
    eof0    = row_position >= rows + ROW_POS_W'(1);
    top_en0 = (row_position >= ROW_POS_W'(2)) && (row_position < rows + ROW_POS_W'(2));
    mid_en0 = (row_position >= ROW_POS_W'(1)) && !eof0;
    bot0    = (row_position < rows) && !pixels.data.flush && pixels.data.pixel;
    emit0   = (row_position >= ROW_POS_W'(2)) ||
              ((row_position == ROW_POS_W'(1)) && (c0 != '0));
  end

  // Advance the raster position on every input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      row_position <= '0;
      col_position <= '0;
    end else if (accept) begin
      if (eof0) begin
        row_position <= '0;
        col_position <= '0;
      end else if (c0_next >= cols) begin
        row_position <= row_position + ROW_POS_W'(1);
        col_position <= '0;
      end else begin
        col_position <= c0_next[CA_W-1:0];
      end
    end
  end

  // Stage 1 registers
  logic            s1_valid;
  logic [CA_W-1:0] s1_col;
  logic            s1_top_en, s1_mid_en, s1_bot, s1_emit, s1_eof, s1_entry_valid;
  logic            fwd_hit;
  logic [1:0]      fwd_data;
  logic            s1_adv;

  // Line buffer: bit 1 is two rows above, bit 0 is one row above
  logic [MAX_COLS-1:0] line_valid;
  logic [1:0]          ram_rdata;
  logic                wr_en;
  logic [1:0]          wr_data;
  logic [1:0]          entry;

  bnc_ram #(
    .WIDTH(2),
    .DEPTH(MAX_COLS)
  ) u_line_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(s1_col),
    .wdata(wr_data),
    .re   (accept),
    .raddr(c0),
    .rdata(ram_rdata)
  );

  // Output register
  logic        o_valid;
  count_item_t o_item;

  assign s1_adv        = !s1_emit || !o_valid || counts.ready;
  assign pixels.ready  = !s1_valid || s1_adv;
  assign accept        = pixels.valid && pixels.ready;
  assign wr_en         = s1_valid && s1_adv;
  assign counts.valid  = o_valid;
  assign counts.data   = o_item;

  // Select the column entry: forwarded write, stored value or never-written zero
  always_comb begin
    if (fwd_hit) begin
      entry = fwd_data;
    end else if (s1_entry_valid) begin
      entry = ram_rdata;
    end else begin
      entry = 2'b00;
    end
    wr_data = {entry[0], s1_bot};
  end

  // Capture the item for stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col         <= c0;
      s1_top_en      <= top_en0;
      s1_mid_en      <= mid_en0;
      s1_bot         <= bot0;
      s1_emit        <= emit0;
      s1_eof         <= eof0;
      s1_entry_valid <= line_valid[c0];
      fwd_hit        <= wr_en && (s1_col == c0);
      fwd_data       <= wr_data;
    end
  end

  // Mark columns written since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid <= '0;
    end else if (wr_en) begin
      line_valid[s1_col] <= 1'b1;
    end
  end

  // Stage 1: slide the window and count
  logic [8:0]         window_bits;
  logic [8:0]         window_next;
  logic [2:0]         newcol;
  logic [COUNT_W-1:0] cnt;

  always_comb begin
    newcol = {s1_top_en & entry[1], s1_mid_en & entry[0], s1_bot};
    if (s1_col == '0) begin
      cnt         = ones9({3'b000, window_bits[5:0]});
      window_next = {6'b0, newcol};
    end else begin
      window_next = {window_bits[5:0], newcol};
      cnt         = ones9(window_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_bits <= '0;
    end else if (wr_en) begin
      window_bits <= window_next;
    end
  end

  // Hold the result until the output transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (wr_en && s1_emit) begin
      o_valid <= 1'b1;
    end else if (counts.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && s1_emit) begin
      o_item.count        <= cnt;
      o_item.end_of_row   <= (s1_col == '0);
      o_item.end_of_frame <= (s1_col == '0) && s1_eof;
    end
  end

endmodule
